>>> rtl/core/aid_pkg.sv
// ----------------------------------------------------------------------------
// aid_pkg: shared definitions for the assembly image deframer
// Item kind codes, parse status codes and the parser phase type.
// ----------------------------------------------------------------------------
package aid_pkg;

   // result item kinds
   localparam logic [3:0] KIND_PARTIAL     = 4'd0;
   localparam logic [3:0] KIND_VERSION_OK  = 4'd1;
   localparam logic [3:0] KIND_ENTRY       = 4'd2;
   localparam logic [3:0] KIND_STR_COUNT   = 4'd3;
   localparam logic [3:0] KIND_STR_LENGTH  = 4'd4;
   localparam logic [3:0] KIND_STR_BYTE    = 4'd5;
   localparam logic [3:0] KIND_INSTR_COUNT = 4'd6;
   localparam logic [3:0] KIND_INSTR_BYTE  = 4'd7;
   localparam logic [3:0] KIND_IGNORED     = 4'd8;

   // parse status
   localparam logic [1:0] STAT_BUSY   = 2'd0;
   localparam logic [1:0] STAT_DONE   = 2'd1;
   localparam logic [1:0] STAT_BADVER = 2'd2;
   localparam logic [1:0] STAT_TRUNC  = 2'd3;

   // last byte position of each header field
   localparam logic [1:0] VERSION_LAST_POS = 2'd1;
   localparam logic [1:0] WORD_LAST_POS    = 2'd3;

   // parser phase, one-hot
   typedef enum logic [6:0] {
      PH_VERSION = 7'b0000001,
      PH_ENTRY   = 7'b0000010,
      PH_SCOUNT  = 7'b0000100,
      PH_SLEN    = 7'b0001000,
      PH_SBYTES  = 7'b0010000,
      PH_ICOUNT  = 7'b0100000,
      PH_IBYTES  = 7'b1000000
   } phase_type;

endpackage

>>> rtl/core/assembly_image_deframer_core.sv
// ----------------------------------------------------------------------------
// assembly_image_deframer_core: byte-wise program image parser
// Tags each image byte with its role, assembles little-endian header fields
// and reports the parse status with every beat.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    data_byte, first_of_image,
//                                              last_of_image
//   rsp      out        rsp_valid/rsp_ready    item_kind, field_value,
//                                              string_number, last_in_section,
//                                              parse_status
//   csr      in         csr_write_enable       csr_write_data (expected version)
//
// one beat per cycle unless rsp stalls: the parser state and the result
// register update on acceptance and the result shows in the cycle after it.
// req_ready is high while the result register is empty or is drained in the
// same cycle, so a stalled rsp side holds off req only by that one register.
// synchronous active-high reset clears the parser to the version field,
// empties the result register and sets the expected version to zero.
//
module assembly_image_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_image,
   input  logic        req_last_of_image,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_item_kind,
   output logic [31:0] rsp_field_value,
   output logic [31:0] rsp_string_number,
   output logic        rsp_last_in_section,
   output logic [1:0]  rsp_parse_status,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   // parser state
   aid_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] strings_left_ff, strings_left_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [31:0] counter_ff, counter_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] version_ff;

   // result register
   logic        rsp_valid_ff;
   logic [3:0]  kind_ff, kind_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] strnum_ff;
   logic        endsec_ff, endsec_in;
   logic [1:0]  rstatus_ff;

   // state as seen after an optional restart
   aid_pkg::phase_type cur_phase;
   logic [1:0]  cur_pos;
   logic [31:0] cur_shift;
   logic [31:0] cur_strings_left;
   logic [31:0] cur_bytes_left;
   logic [31:0] cur_counter;
   logic [1:0]  cur_status;

   logic [31:0] assembled;
   logic [31:0] bytes_dec;
   logic [31:0] strings_dec;
   logic [31:0] counter_inc;
   logic [1:0]  last_pos;
   logic        accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // restart view
   always_comb begin
      if (req_first_of_image) begin
         cur_phase        = aid_pkg::PH_VERSION;
         cur_pos          = 2'd0;
         cur_shift        = 32'd0;
         cur_strings_left = 32'd0;
         cur_bytes_left   = 32'd0;
         cur_counter      = 32'd0;
         cur_status       = aid_pkg::STAT_BUSY;
      end else begin
         cur_phase        = phase_ff;
         cur_pos          = pos_ff;
         cur_shift        = shift_ff;
         cur_strings_left = strings_left_ff;
         cur_bytes_left   = bytes_left_ff;
         cur_counter      = counter_ff;
         cur_status       = status_ff;
      end
   end

   // shared arithmetic
   assign assembled   = cur_shift | ({24'd0, req_data_byte} << {cur_pos, 3'b000});
   assign bytes_dec   = cur_bytes_left - 32'd1;
   assign strings_dec = cur_strings_left - 32'd1;
   assign counter_inc = cur_counter + 32'd1;
   assign last_pos    = (cur_phase == aid_pkg::PH_VERSION) ?
                        aid_pkg::VERSION_LAST_POS : aid_pkg::WORD_LAST_POS;

   // next state and result for one beat
   always_comb begin
      phase_in        = cur_phase;
      pos_in          = cur_pos;
      shift_in        = cur_shift;
      strings_left_in = cur_strings_left;
      bytes_left_in   = cur_bytes_left;
      counter_in      = cur_counter;
      status_in       = cur_status;
      kind_in         = aid_pkg::KIND_PARTIAL;
      value_in        = 32'd0;
      endsec_in       = 1'b0;

      if (cur_status != aid_pkg::STAT_BUSY) begin
         kind_in = aid_pkg::KIND_IGNORED;
      end else if (cur_phase == aid_pkg::PH_SBYTES || cur_phase == aid_pkg::PH_IBYTES) begin
         // content byte
         kind_in       = (cur_phase == aid_pkg::PH_SBYTES) ?
                         aid_pkg::KIND_STR_BYTE : aid_pkg::KIND_INSTR_BYTE;
         value_in      = {24'd0, req_data_byte};
         bytes_left_in = bytes_dec;
         if (bytes_dec == 32'd0) begin
            endsec_in = 1'b1;
            if (cur_phase == aid_pkg::PH_SBYTES) begin
               counter_in      = counter_inc;
               strings_left_in = strings_dec;
               phase_in        = (strings_dec == 32'd0) ? aid_pkg::PH_ICOUNT : aid_pkg::PH_SLEN;
            end else begin
               status_in = aid_pkg::STAT_DONE;
            end
         end
      end else begin
         // header field byte
         value_in = assembled;
         shift_in = assembled;
         if (cur_pos != last_pos) begin
            pos_in = cur_pos + 2'd1;
         end else begin
            pos_in   = 2'd0;
            shift_in = 32'd0;
            unique case (cur_phase)
               aid_pkg::PH_VERSION: begin
                  if (assembled == {16'd0, version_ff}) begin
                     kind_in  = aid_pkg::KIND_VERSION_OK;
                     phase_in = aid_pkg::PH_ENTRY;
                  end else begin
                     status_in = aid_pkg::STAT_BADVER;
                  end
               end
               aid_pkg::PH_ENTRY: begin
                  kind_in  = aid_pkg::KIND_ENTRY;
                  phase_in = aid_pkg::PH_SCOUNT;
               end
               aid_pkg::PH_SCOUNT: begin
                  kind_in         = aid_pkg::KIND_STR_COUNT;
                  strings_left_in = assembled;
                  counter_in      = 32'd0;
                  phase_in        = (assembled == 32'd0) ? aid_pkg::PH_ICOUNT : aid_pkg::PH_SLEN;
               end
               aid_pkg::PH_SLEN: begin
                  kind_in       = aid_pkg::KIND_STR_LENGTH;
                  bytes_left_in = assembled;
                  if (assembled == 32'd0) begin
                     counter_in      = counter_inc;
                     strings_left_in = strings_dec;
                     phase_in        = (strings_dec == 32'd0) ?
                                       aid_pkg::PH_ICOUNT : aid_pkg::PH_SLEN;
                  end else begin
                     phase_in = aid_pkg::PH_SBYTES;
                  end
               end
               default: begin
                  kind_in       = aid_pkg::KIND_INSTR_COUNT;
                  bytes_left_in = assembled;
                  if (assembled == 32'd0) begin
                     status_in = aid_pkg::STAT_DONE;
                  end else begin
                     phase_in = aid_pkg::PH_IBYTES;
                  end
               end
            endcase
         end
      end

      // early last mark
      if (req_last_of_image && status_in == aid_pkg::STAT_BUSY) begin
         status_in = aid_pkg::STAT_TRUNC;
      end
   end

   // state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= aid_pkg::PH_VERSION;
         pos_ff          <= 2'd0;
         shift_ff        <= 32'd0;
         strings_left_ff <= 32'd0;
         bytes_left_ff   <= 32'd0;
         counter_ff      <= 32'd0;
         status_ff       <= aid_pkg::STAT_BUSY;
         version_ff      <= 16'd0;
      end else begin
         if (csr_write_enable) begin
            version_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff        <= phase_in;
            pos_ff          <= pos_in;
            shift_ff        <= shift_in;
            strings_left_ff <= strings_left_in;
            bytes_left_ff   <= bytes_left_in;
            counter_ff      <= counter_in;
            status_ff       <= status_in;
         end
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= kind_in;
         value_ff   <= value_in;
         strnum_ff  <= cur_counter;
         endsec_ff  <= endsec_in;
         rstatus_ff <= status_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_item_kind       = kind_ff;
   assign rsp_field_value     = value_ff;
   assign rsp_string_number   = strnum_ff;
   assign rsp_last_in_section = endsec_ff;
   assign rsp_parse_status    = rstatus_ff;

   // an ignored byte only follows a finished or failed image
   a_ignored_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item_kind == aid_pkg::KIND_IGNORED) |->
      (rsp_parse_status != aid_pkg::STAT_BUSY))
      else $error("ignored byte reported while parse in progress");

   // section end only on content bytes
   a_endsec_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_in_section) |->
      (rsp_item_kind == aid_pkg::KIND_STR_BYTE || rsp_item_kind == aid_pkg::KIND_INSTR_BYTE))
      else $error("section end flagged on a non-content byte");

   // a last-marked beat always leaves the parser out of progress
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_of_image) |=> (status_ff != aid_pkg::STAT_BUSY))
      else $error("parser still busy after last byte of image");

   // the result register mirrors the status after each beat
   a_status_track: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid && rsp_parse_status == status_ff))
      else $error("reported status differs from parser status");

endmodule
